// File: design/hig_pkg.sv
// Shared constants and types of the hyperexponential interval generator.
`timescale 1ns / 1ps

package hig_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_ONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_TWO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd4;

  // Register reset values
  localparam logic [30:0] SEED_RST      = 31'd1;
  localparam logic [23:0] MEAN_ONE_RST  = 24'd6554;
  localparam logic [23:0] MEAN_TWO_RST  = 24'd65536;
  localparam logic [30:0] THRESHOLD_RST = 31'd536870912;
  localparam logic [31:0] PERIOD_RST    = 32'd655360;

  // Arithmetic constants
  localparam logic [31:0] GEN_MUL      = 32'd16807;
  localparam logic [30:0] GEN_MOD      = 31'h7FFF_FFFF;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [28:0] LOG2_MOD_Q24 = 29'h1F00_0000;
  localparam logic [4:0]  LOG_ITERS    = 5'd24;

  // Generator load request from the configuration port
  typedef struct packed {
    logic        load;
    logic [30:0] value;
  } hig_seed_t;

  // Handshake control from the top level to the core
  typedef struct packed {
    logic start;
    logic restart;
    logic out_free;
  } hig_ctl_t;

  // One finished result from the core
  typedef struct packed {
    logic        valid;
    logic [31:0] interval;
    logic        branch;
    logic        done;
  } hig_result_t;

endpackage

// File: design/hig_mul.sv
// Shared 32 by 32 unsigned multiplier of the interval generator.
`timescale 1ns / 1ps

module hig_mul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  assign p = {32'd0, a} * {32'd0, b};

endmodule

// File: design/hig_core.sv
// Sequencer and datapath: generator steps, logarithm, scaling and period sum.
`timescale 1ns / 1ps

module hig_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hig_pkg::hig_ctl_t    ctl,
  input  hig_pkg::hig_seed_t   seed,
  input  logic [23:0]          mean_one,
  input  logic [23:0]          mean_two,
  input  logic [30:0]          threshold,
  input  logic [31:0]          period,
  output logic                 idle,
  output hig_pkg::hig_result_t result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_G1M  = 4'd1;
  localparam logic [3:0] S_G1F  = 4'd2;
  localparam logic [3:0] S_G2M  = 4'd3;
  localparam logic [3:0] S_G2F  = 4'd4;
  localparam logic [3:0] S_NRM  = 4'd5;
  localparam logic [3:0] S_SQR  = 4'd6;
  localparam logic [3:0] S_DIF  = 4'd7;
  localparam logic [3:0] S_LNM  = 4'd8;
  localparam logic [3:0] S_RND  = 4'd9;
  localparam logic [3:0] S_MNM  = 4'd10;
  localparam logic [3:0] S_IVS  = 4'd11;
  localparam logic [3:0] S_ACC  = 4'd12;

  logic [3:0]  state_r,   state_nxt;
  logic [4:0]  cnt_r,     cnt_nxt;
  logic [30:0] x_r,       x_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic        restart_r, restart_nxt;
  logic        branch_r,  branch_nxt;
  logic [30:0] t_r,       t_nxt;
  logic [4:0]  sh_r,      sh_nxt;
  logic [23:0] frac_r,    frac_nxt;
  logic [31:0] op_r,      op_nxt;
  logic [63:0] prod_r,    prod_nxt;
  logic [31:0] iv_r,      iv_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] fold_sum, fold_red;
  logic [31:0] sq_top;
  logic [4:0]  lead_n;
  logic [63:0] rnd_sum;
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic        acc_done;

  hig_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_G1M, S_G2M: begin
        mul_a = {1'b0, x_r};
        mul_b = hig_pkg::GEN_MUL;
      end
      S_SQR: begin
        mul_a = {1'b0, t_r};
        mul_b = {1'b0, t_r};
      end
      S_LNM: begin
        mul_a = op_r;
        mul_b = hig_pkg::LN2_Q32;
      end
      S_MNM: begin
        mul_a = {8'd0, branch_r ? mean_two : mean_one};
        mul_b = op_r;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Reduction modulo 2^31-1: fold the high bits onto the low bits once.
  assign fold_sum = {1'b0, prod_r[30:0]} + {17'd0, prod_r[45:31]};
  assign fold_red = (fold_sum >= {1'b0, hig_pkg::GEN_MOD}) ?
                    (fold_sum - {1'b0, hig_pkg::GEN_MOD}) : fold_sum;

  assign sq_top  = mul_p[61:30];
  assign lead_n  = 5'd30 - sh_r;
  assign rnd_sum = prod_r + (64'd1 << 31);

  assign acc_sum  = {1'b0, restart_r ? 32'd0 : elapsed_r} + {1'b0, iv_r};
  assign acc_sat  = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign acc_done = (acc_sat >= period);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    x_nxt       = x_r;
    elapsed_nxt = elapsed_r;
    restart_nxt = restart_r;
    branch_nxt  = branch_r;
    t_nxt       = t_r;
    sh_nxt      = sh_r;
    frac_nxt    = frac_r;
    op_nxt      = op_r;
    prod_nxt    = prod_r;
    iv_nxt      = iv_r;

    result.valid    = 1'b0;
    result.interval = iv_r;
    result.branch   = branch_r;
    result.done     = acc_done;

    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          restart_nxt = ctl.restart;
          state_nxt   = S_G1M;
        end
      end
      S_G1M: begin
        prod_nxt  = mul_p;
        state_nxt = S_G1F;
      end
      S_G1F: begin
        x_nxt     = fold_red[30:0];
        state_nxt = S_G2M;
      end
      S_G2M: begin
        branch_nxt = (x_r > threshold);
        prod_nxt   = mul_p;
        state_nxt  = S_G2F;
      end
      S_G2F: begin
        x_nxt     = fold_red[30:0];
        t_nxt     = fold_red[30:0];
        sh_nxt    = 5'd0;
        frac_nxt  = 24'd0;
        cnt_nxt   = 5'd0;
        state_nxt = S_NRM;
      end
      S_NRM: begin
        // Leading-one search in five halving steps.
        unique case (cnt_r[2:0])
          3'd0: if (t_r[30:15] == 16'd0) begin
            t_nxt  = {t_r[14:0], 16'd0};
            sh_nxt = sh_r + 5'd16;
          end
          3'd1: if (t_r[30:23] == 8'd0) begin
            t_nxt  = {t_r[22:0], 8'd0};
            sh_nxt = sh_r + 5'd8;
          end
          3'd2: if (t_r[30:27] == 4'd0) begin
            t_nxt  = {t_r[26:0], 4'd0};
            sh_nxt = sh_r + 5'd4;
          end
          3'd3: if (t_r[30:29] == 2'd0) begin
            t_nxt  = {t_r[28:0], 2'd0};
            sh_nxt = sh_r + 5'd2;
          end
          3'd4: if (!t_r[30]) begin
            t_nxt  = {t_r[29:0], 1'b0};
            sh_nxt = sh_r + 5'd1;
          end
          default: begin
            t_nxt = t_r;
          end
        endcase
        if (cnt_r == 5'd4) begin
          cnt_nxt   = 5'd0;
          state_nxt = S_SQR;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_SQR: begin
        // Square the mantissa; a carry past two gives the next fraction bit.
        frac_nxt = {frac_r[22:0], sq_top[31]};
        t_nxt    = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
        if (cnt_r == hig_pkg::LOG_ITERS - 5'd1) begin
          state_nxt = S_DIF;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DIF: begin
        op_nxt    = {3'd0, hig_pkg::LOG2_MOD_Q24 - {lead_n, frac_r}};
        state_nxt = S_LNM;
      end
      S_LNM: begin
        prod_nxt  = mul_p;
        state_nxt = S_RND;
      end
      S_RND: begin
        op_nxt    = rnd_sum[63:32];
        state_nxt = S_MNM;
      end
      S_MNM: begin
        prod_nxt  = mul_p + (64'd1 << 23);
        state_nxt = S_IVS;
      end
      S_IVS: begin
        iv_nxt    = (prod_r[63:56] != 8'd0) ? 32'hFFFF_FFFF : prod_r[55:24];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (ctl.out_free) begin
          result.valid = 1'b1;
          elapsed_nxt  = acc_done ? 32'd0 : acc_sat;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (seed.load) begin
      x_nxt = seed.value;
    end
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= 5'd0;
      x_r       <= hig_pkg::SEED_RST;
      elapsed_r <= 32'd0;
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      x_r       <= x_nxt;
      elapsed_r <= elapsed_nxt;
      restart_r <= restart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    branch_r <= branch_nxt;
    t_r      <= t_nxt;
    sh_r     <= sh_nxt;
    frac_r   <= frac_nxt;
    op_r     <= op_nxt;
    prod_r   <= prod_nxt;
    iv_r     <= iv_nxt;
  end

endmodule

// File: design/hyperexponential_interval_generator.sv
// Top level of the hyperexponential interval generator.
// The core holds in_tready low while it works, so a new beat is not taken until the last result has left the core.
// The logarithm runs a 24-step squaring loop on the shared multiplier.
// Reset (rst_n low, synchronous) restores register defaults, state 1 and a zero sum.
`timescale 1ns / 1ps

module hyperexponential_interval_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] restart, [7:1] zero
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [31:0] interval
  output logic                             out_tuser,  // [0] branch_taken
  output logic                             out_tlast,  // period_done
  // Configuration writes
  input  logic                             cfg_we,
  input  logic [hig_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hig_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers. The seed is not kept: a write goes straight
  // into the generator state, with the two degenerate values mapped to 1.
  logic [23:0] mean_one_r,  mean_one_nxt;
  logic [23:0] mean_two_r,  mean_two_nxt;
  logic [30:0] threshold_r, threshold_nxt;
  logic [31:0] period_r,    period_nxt;

  // Output register that decouples the core from the result stream.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_iv_r,    out_iv_nxt;
  logic        out_br_r,    out_br_nxt;
  logic        out_done_r,  out_done_nxt;

  hig_pkg::hig_seed_t   seed;
  hig_pkg::hig_ctl_t    ctl;
  hig_pkg::hig_result_t res;
  logic                 core_idle;
  logic [30:0]          seed_raw;

  assign seed_raw   = cfg_data[30:0];
  assign seed.load  = cfg_we && (cfg_index == hig_pkg::REG_SEED);
  assign seed.value = ((seed_raw == 31'd0) || (seed_raw == hig_pkg::GEN_MOD)) ?
                      31'd1 : seed_raw;

  always_comb begin
    mean_one_nxt  = mean_one_r;
    mean_two_nxt  = mean_two_r;
    threshold_nxt = threshold_r;
    period_nxt    = period_r;
    if (cfg_we) begin
      unique case (cfg_index)
        hig_pkg::REG_MEAN_ONE:  mean_one_nxt  = cfg_data[23:0];
        hig_pkg::REG_MEAN_TWO:  mean_two_nxt  = cfg_data[23:0];
        hig_pkg::REG_THRESHOLD: threshold_nxt = cfg_data[30:0];
        hig_pkg::REG_PERIOD:    period_nxt    = cfg_data[31:0];
        default: begin
          // The seed is handled by the core; unknown indexes are ignored.
          period_nxt = period_r;
        end
      endcase
    end
  end

  // A new beat is taken whenever the core is idle; a finished result may
  // still sit in the output register while the next draw is computed.
  assign in_tready    = core_idle;
  assign ctl.start    = in_tvalid && core_idle;
  assign ctl.restart  = in_tdata[0];
  assign ctl.out_free = !out_valid_r || out_tready;

  hig_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .seed      (seed),
    .mean_one  (mean_one_r),
    .mean_two  (mean_two_r),
    .threshold (threshold_r),
    .period    (period_r),
    .idle      (core_idle),
    .result    (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_iv_nxt    = out_iv_r;
    out_br_nxt    = out_br_r;
    out_done_nxt  = out_done_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_iv_nxt    = res.interval;
      out_br_nxt    = res.branch;
      out_done_nxt  = res.done;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_one_r  <= hig_pkg::MEAN_ONE_RST;
      mean_two_r  <= hig_pkg::MEAN_TWO_RST;
      threshold_r <= hig_pkg::THRESHOLD_RST;
      period_r    <= hig_pkg::PERIOD_RST;
      out_valid_r <= 1'b0;
    end else begin
      mean_one_r  <= mean_one_nxt;
      mean_two_r  <= mean_two_nxt;
      threshold_r <= threshold_nxt;
      period_r    <= period_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_iv_r   <= out_iv_nxt;
    out_br_r   <= out_br_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_iv_r;
  assign out_tuser  = out_br_r;
  assign out_tlast  = out_done_r;

endmodule
